@@ rtl/core/cwpp_pkg.sv @@
// Package for the capture word post-processing unit.
// Holds the register map, reset values, result types and word transforms.
// Depends on nothing; imported by capture_word_postprocess_unit.
package cwpp_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned SKIP_W  = 20;
    localparam int unsigned INDEX_W = 24;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W   = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W   = $clog2(FIFO_DEPTH + 1);

    // Register indexes, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_DEDUP_ENABLE = 3'd0,
        REG_LEAD_SKIP    = 3'd1,
        REG_DROP_ZEROS   = 3'd2,
        REG_WORD_GOAL    = 3'd3,
        REG_SWAP_BYTES   = 3'd4,
        REG_REVERSE_BITS = 3'd5,
        REG_SERIAL_MSB   = 3'd6
    } t_reg_idx;

    // Reset values of the registers.
    localparam logic [SKIP_W-1:0]  LEAD_SKIP_RST = 20'd37500;
    localparam logic [INDEX_W-1:0] WORD_GOAL_RST = 24'hFFFFFF;

    typedef struct packed {
        logic               dedup_enable;
        logic [SKIP_W-1:0]  lead_skip;
        logic               drop_zeros;
        logic [INDEX_W-1:0] word_goal;
        logic               swap_bytes;
        logic               reverse_bits;
        logic               serial_msb;
    } t_cfg;

    // One result beat as it sits in the output buffer.
    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [INDEX_W-1:0] index;
        logic               item_end;
    } t_result;

    // Outcome of passing one deduplicated word through skip, zero drop and goal.
    typedef struct packed {
        logic               emit;
        logic [WORD_W-1:0]  word;
        logic [INDEX_W-1:0] index;
        logic [SKIP_W-1:0]  passed;
        logic [INDEX_W-1:0] kept;
    } t_post;

    function automatic logic [WORD_W-1:0] byte_swap(input logic [WORD_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Reverse the bit order inside every byte.
    function automatic logic [WORD_W-1:0] bits_in_bytes(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] x;
        x = ((v & {4{8'h55}}) << 1) | ((v & {4{8'hAA}}) >> 1);
        x = ((x & {4{8'h33}}) << 2) | ((x & {4{8'hCC}}) >> 2);
        x = ((x & {4{8'h0F}}) << 4) | ((x & {4{8'hF0}}) >> 4);
        return x;
    endfunction

    function automatic logic [WORD_W-1:0] full_reverse(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < WORD_W; i++) begin
            r[WORD_W-1-i] = v[i];
        end
        return r;
    endfunction

    // Skip, zero drop, goal check and output transforms for one word.
    function automatic t_post post_stage(input logic [WORD_W-1:0]  w,
                                         input logic [SKIP_W-1:0]  passed,
                                         input logic [INDEX_W-1:0] kept,
                                         input t_cfg               cfg);
        t_post             p;
        logic [WORD_W-1:0] x;
        p.emit   = 1'b0;
        p.index  = kept;
        p.passed = passed;
        p.kept   = kept;
        x = cfg.swap_bytes ? byte_swap(w) : w;
        x = cfg.reverse_bits ? bits_in_bytes(x) : x;
        x = cfg.serial_msb ? full_reverse(x) : x;
        p.word = x;
        if (passed < cfg.lead_skip) begin
            p.passed = passed + SKIP_W'(1);
        end else if (cfg.drop_zeros && (w == '0)) begin
            p.emit = 1'b0;
        end else if (kept < cfg.word_goal) begin
            p.emit = 1'b1;
            p.kept = kept + INDEX_W'(1);
        end
        return p;
    endfunction

endpackage

@@ rtl/core/capture_word_postprocess_unit.sv @@
// Capture word post-processing unit: dedup, skip, zero drop, goal and transforms.
// Results enter the buffer when the input beat releasing them is accepted and are
// presented from its head. One input beat per cycle while not stalled; a beat
// yielding two results pushes both; input stall rises while the four-entry buffer
// holds three or more beats. Reset (synchronous, active low) restores register
// defaults, clears the pending word and both counters, and empties the buffer.
// Depends on cwpp_pkg.
module capture_word_postprocess_unit
    import cwpp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [WORD_W-1:0]   i_in_word,
    input  logic                i_end_of_capture,
    // Result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [WORD_W-1:0]   o_out_word,
    output logic [INDEX_W-1:0]  o_out_index,
    output logic                o_item_end,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    t_cfg               r_cfg;
    logic [WORD_W-1:0]  r_pend_word, n_pend_word;
    logic               r_pend_valid, n_pend_valid;
    logic [SKIP_W-1:0]  r_passed, n_passed;
    logic [INDEX_W-1:0] r_kept, n_kept;

    t_result            r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    logic     in_beat, out_beat, cfg_wr, words_eq;
    logic     a_valid, b_valid;
    t_post    post_a, post_b;
    t_result  res_a, res_b, first_res;
    logic [1:0] push_n;
    t_reg_idx reg_idx;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign reg_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);

    assign o_in_stall = (r_count > CNT_W'(FIFO_DEPTH - 2));
    assign in_beat    = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != '0);
    assign out_beat   = o_out_valid && !i_out_stall;

    // Register read-back.
    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_DEDUP_ENABLE: prdata = {31'd0, r_cfg.dedup_enable};
            REG_LEAD_SKIP:    prdata = {12'd0, r_cfg.lead_skip};
            REG_DROP_ZEROS:   prdata = {31'd0, r_cfg.drop_zeros};
            REG_WORD_GOAL:    prdata = {8'd0, r_cfg.word_goal};
            REG_SWAP_BYTES:   prdata = {31'd0, r_cfg.swap_bytes};
            REG_REVERSE_BITS: prdata = {31'd0, r_cfg.reverse_bits};
            REG_SERIAL_MSB:   prdata = {31'd0, r_cfg.serial_msb};
            default:          prdata = '0;
        endcase
    end

    // Pair dedup picks up to two candidate words: the pending word, then the new one.
    assign words_eq = r_pend_valid && (i_in_word == r_pend_word);
    assign a_valid  = r_pend_valid;
    assign b_valid  = r_cfg.dedup_enable ? (i_end_of_capture && !words_eq) : 1'b1;

    // The two candidates pass the post stage in order, the second seeing the
    // counters as the first leaves them.
    always_comb begin
        post_a = post_stage(r_pend_word, r_passed, r_kept, r_cfg);
        post_a.emit = post_a.emit && a_valid;
        if (!a_valid) begin
            post_a.passed = r_passed;
            post_a.kept   = r_kept;
        end
        post_b = post_stage(i_in_word, post_a.passed, post_a.kept, r_cfg);
        post_b.emit = post_b.emit && b_valid;
        if (!b_valid) begin
            post_b.passed = post_a.passed;
            post_b.kept   = post_a.kept;
        end
    end

    // Next pending word and counters; end of capture clears everything.
    always_comb begin
        n_passed     = post_b.passed;
        n_kept       = post_b.kept;
        n_pend_valid = r_cfg.dedup_enable && !words_eq;
        n_pend_word  = (r_cfg.dedup_enable && !words_eq) ? i_in_word : r_pend_word;
        if (i_end_of_capture) begin
            n_passed     = '0;
            n_kept       = '0;
            n_pend_valid = 1'b0;
            n_pend_word  = '0;
        end
    end

    // Result beats for the buffer; the last one of the item carries item_end.
    always_comb begin
        res_a.word     = post_a.word;
        res_a.index    = post_a.index;
        res_a.item_end = !post_b.emit;
        res_b.word     = post_b.word;
        res_b.index    = post_b.index;
        res_b.item_end = 1'b1;
        first_res      = post_a.emit ? res_a : res_b;
        push_n         = in_beat ? ({1'b0, post_a.emit} + {1'b0, post_b.emit}) : 2'd0;
    end

    assign o_out_word  = r_fifo[r_rd_ptr].word;
    assign o_out_index = r_fifo[r_rd_ptr].index;
    assign o_item_end  = r_fifo[r_rd_ptr].item_end;

    // Buffer payload, no reset needed.
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= first_res;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= res_b;
        end
    end

    // Control state, counters and registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dedup_enable <= 1'b0;
            r_cfg.lead_skip    <= LEAD_SKIP_RST;
            r_cfg.drop_zeros   <= 1'b1;
            r_cfg.word_goal    <= WORD_GOAL_RST;
            r_cfg.swap_bytes   <= 1'b0;
            r_cfg.reverse_bits <= 1'b0;
            r_cfg.serial_msb   <= 1'b0;
            r_pend_word        <= '0;
            r_pend_valid       <= 1'b0;
            r_passed           <= '0;
            r_kept             <= '0;
            r_wr_ptr           <= '0;
            r_rd_ptr           <= '0;
            r_count            <= '0;
        end else begin
            if (cfg_wr) begin
                case (reg_idx)
                    REG_DEDUP_ENABLE: r_cfg.dedup_enable <= pwdata[0];
                    REG_LEAD_SKIP:    r_cfg.lead_skip    <= pwdata[SKIP_W-1:0];
                    REG_DROP_ZEROS:   r_cfg.drop_zeros   <= pwdata[0];
                    REG_WORD_GOAL:    r_cfg.word_goal    <= pwdata[INDEX_W-1:0];
                    REG_SWAP_BYTES:   r_cfg.swap_bytes   <= pwdata[0];
                    REG_REVERSE_BITS: r_cfg.reverse_bits <= pwdata[0];
                    REG_SERIAL_MSB:   r_cfg.serial_msb   <= pwdata[0];
                    default: ;
                endcase
            end
            if (in_beat) begin
                r_pend_word  <= n_pend_word;
                r_pend_valid <= n_pend_valid;
                r_passed     <= n_passed;
                r_kept       <= n_kept;
            end
            r_wr_ptr <= r_wr_ptr + PTR_W'(push_n);
            if (out_beat) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(push_n) - CNT_W'(out_beat);
        end
    end

endmodule

@@ tb/capture_word_postprocess_unit_test.sv @@
// Self-checking testbench for capture_word_postprocess_unit: directed and random word streams.
// A behavioral predictor tracks dedup, skip, zero drop, goal and transforms for every beat.
// Depends on cwpp_pkg and the capture_word_postprocess_unit RTL.
module capture_word_postprocess_unit_test
    import cwpp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned RANDOM_BEATS  = 1500;
    localparam logic [2:0]  UNMAPPED_REG  = 3'd7;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              eoc;
    } t_capture_beat;

    // Block ports.
    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_in_valid       = 1'b0;
    logic                o_in_stall;
    logic [WORD_W-1:0]   i_in_word        = '0;
    logic                i_end_of_capture = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall      = 1'b0;
    logic [WORD_W-1:0]   o_out_word;
    logic [INDEX_W-1:0]  o_out_index;
    logic                o_item_end;
    logic                psel             = 1'b0;
    logic                penable          = 1'b0;
    logic                pwrite           = 1'b0;
    logic [ADDR_W-1:0]   paddr            = '0;
    logic [31:0]         pwdata           = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Stimulus, expectations and predictor state.
    t_capture_beat       raw_words_q[$];
    t_result             expected_words[$];
    t_result             beat_words[$];
    t_cfg                cfg_mirror;
    logic [WORD_W-1:0]   held_word;
    logic                held_valid;
    logic [SKIP_W-1:0]   skipped_cnt;
    logic [INDEX_W-1:0]  emitted_cnt;
    logic                in_beat_taken = 1'b0;
    logic                steady        = 1'b0;
    int unsigned         gap_left      = 0;
    int unsigned         stall_left    = 0;
    int unsigned         err_count     = 0;
    int unsigned         cycle_cnt     = 0;

    capture_word_postprocess_unit DUT (.*);

    // Clock: 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Gap length: mostly none, sometimes short, rarely long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (steady || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    // Output word ordering: byte swap, bit reverse in bytes, then full reverse.
    function automatic logic [WORD_W-1:0] arrange_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        x = w;
        if (cfg_mirror.swap_bytes) begin
            for (int b = 0; b < 4; b++) y[8*b +: 8] = x[8*(3-b) +: 8];
            x = y;
        end
        if (cfg_mirror.reverse_bits) begin
            for (int i = 0; i < 32; i++) y[i] = x[8*(i/8) + 7 - (i%8)];
            x = y;
        end
        if (cfg_mirror.serial_msb) begin
            for (int i = 0; i < 32; i++) y[i] = x[31-i];
            x = y;
        end
        return x;
    endfunction

    // One deduplicated word through skip, zero drop and goal.
    task automatic stage_word(input logic [WORD_W-1:0] w);
        t_result r;
        if (skipped_cnt < cfg_mirror.lead_skip) begin
            skipped_cnt = skipped_cnt + 1'b1;
        end else if (!(cfg_mirror.drop_zeros && w == '0) &&
                     emitted_cnt < cfg_mirror.word_goal) begin
            r.word     = arrange_word(w);
            r.index    = emitted_cnt;
            r.item_end = 1'b0;
            beat_words.push_back(r);
            emitted_cnt = emitted_cnt + 1'b1;
        end
    endtask

    // Expected results of one accepted input beat.
    task automatic predict_cleanup(input logic [WORD_W-1:0] w, input logic last);
        t_result r;
        beat_words.delete();
        if (cfg_mirror.dedup_enable) begin
            if (!held_valid) begin
                held_word  = w;
                held_valid = 1'b1;
            end else if (w == held_word) begin
                stage_word(held_word);
                held_valid = 1'b0;
            end else begin
                stage_word(held_word);
                held_word = w;
            end
        end else begin
            if (held_valid) begin
                stage_word(held_word);
                held_valid = 1'b0;
            end
            stage_word(w);
        end
        // End of capture flushes the held word and clears the counters.
        if (last) begin
            if (held_valid) begin
                stage_word(held_word);
            end
            held_word   = '0;
            held_valid  = 1'b0;
            skipped_cnt = '0;
            emitted_cnt = '0;
        end
        foreach (beat_words[i]) begin
            r = beat_words[i];
            r.item_end = (i == beat_words.size() - 1);
            expected_words.push_back(r);
        end
    endtask

    task automatic push_raw(input logic [WORD_W-1:0] w, input logic eoc);
        t_capture_beat b;
        b.word = w;
        b.eoc  = eoc;
        raw_words_q.push_back(b);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait until every beat is sent and every result has come back.
    task automatic settle();
        do @(posedge i_clk);
        while (raw_words_q.size() != 0 || i_in_valid || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] draw_word(input logic [WORD_W-1:0] prev);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) return prev;
        if (r < 42) return '0;
        if (r < 50) return '1;
        if (r < 56) return 32'h1 << $urandom_range(31);
        return $urandom();
    endfunction

    // Input driver: presents queued beats with random gaps.
    always @(negedge i_clk) begin : drive_input
        logic              nv;
        logic [WORD_W-1:0] nw;
        logic              ne;
        t_capture_beat     b;
        nv = i_in_valid;
        nw = i_in_word;
        ne = i_end_of_capture;
        if (i_rst_n) begin
            if (i_in_valid && in_beat_taken) begin
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (raw_words_q.size() != 0) begin
                    b  = raw_words_q.pop_front();
                    nv = 1'b1;
                    nw = b.word;
                    ne = b.eoc;
                    gap_left = pick_gap();
                end
            end
        end
        i_in_valid       <= nv;
        i_in_word        <= nw;
        i_end_of_capture <= ne;
    end

    // Result side back-pressure.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            stall_left = pick_gap();
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: check result beats, track register writes, predict input beats.
    always @(posedge i_clk) begin : watch
        t_result exp_r;
        in_beat_taken = 1'b0;
        if (!i_rst_n) begin
            cfg_mirror.dedup_enable = 1'b0;
            cfg_mirror.lead_skip    = LEAD_SKIP_RST;
            cfg_mirror.drop_zeros   = 1'b1;
            cfg_mirror.word_goal    = WORD_GOAL_RST;
            cfg_mirror.swap_bytes   = 1'b0;
            cfg_mirror.reverse_bits = 1'b0;
            cfg_mirror.serial_msb   = 1'b0;
            held_word   = '0;
            held_valid  = 1'b0;
            skipped_cnt = '0;
            emitted_cnt = '0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result beat: out_word %h out_index %0d",
                           o_out_word, o_out_index);
                    err_count++;
                end else begin
                    exp_r = expected_words.pop_front();
                    if (o_out_word !== exp_r.word) begin
                        $error("out_word: expected %h, actual %h", exp_r.word, o_out_word);
                        err_count++;
                    end
                    if (o_out_index !== exp_r.index) begin
                        $error("out_index: expected %0d, actual %0d",
                               exp_r.index, o_out_index);
                        err_count++;
                    end
                    if (o_item_end !== exp_r.item_end) begin
                        $error("item_end: expected %b, actual %b",
                               exp_r.item_end, o_item_end);
                        err_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_DEDUP_ENABLE: cfg_mirror.dedup_enable = pwdata[0];
                    REG_LEAD_SKIP:    cfg_mirror.lead_skip    = pwdata[SKIP_W-1:0];
                    REG_DROP_ZEROS:   cfg_mirror.drop_zeros   = pwdata[0];
                    REG_WORD_GOAL:    cfg_mirror.word_goal    = pwdata[INDEX_W-1:0];
                    REG_SWAP_BYTES:   cfg_mirror.swap_bytes   = pwdata[0];
                    REG_REVERSE_BITS: cfg_mirror.reverse_bits = pwdata[0];
                    REG_SERIAL_MSB:   cfg_mirror.serial_msb   = pwdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                in_beat_taken = 1'b1;
                predict_cleanup(i_in_word, i_end_of_capture);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL capture_word_postprocess_unit");
            $finish;
        end
    end

    // Test sequence.
    initial begin : run
        int unsigned       sent;
        int unsigned       n;
        int unsigned       r;
        logic [WORD_W-1:0] w;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings skip far more words than these two.
        push_raw(32'hDEADBEEF, 1'b0);
        push_raw(32'h00000000, 1'b1);
        settle();

        // Plain pass-through, zeros kept; a write to an unmapped index is ignored.
        set_reg(REG_LEAD_SKIP, 32'd0);
        set_reg(REG_DROP_ZEROS, 32'd0);
        set_reg(REG_WORD_GOAL, 32'hFFFFFF);
        set_reg(UNMAPPED_REG, 32'hFFFFFFFF);
        push_raw(32'h00000000, 1'b0);
        push_raw(32'hFFFFFFFF, 1'b0);
        push_raw(32'h80000001, 1'b1);
        settle();

        // All transforms on, zeros dropped.
        set_reg(REG_DROP_ZEROS, 32'd1);
        set_reg(REG_SWAP_BYTES, 32'd1);
        set_reg(REG_REVERSE_BITS, 32'd1);
        set_reg(REG_SERIAL_MSB, 32'd1);
        push_raw(32'h00000000, 1'b0);
        push_raw(32'h12345678, 1'b0);
        push_raw(32'hA5C30F01, 1'b1);
        settle();

        // Pair dedup with a short skip; the last word is flushed at end of capture.
        set_reg(REG_SERIAL_MSB, 32'd0);
        set_reg(REG_DEDUP_ENABLE, 32'd1);
        set_reg(REG_LEAD_SKIP, 32'd2);
        push_raw(32'h11111111, 1'b0);
        push_raw(32'h11111111, 1'b0);
        push_raw(32'h00000000, 1'b0);
        push_raw(32'hFFFFFFFF, 1'b0);
        push_raw(32'hFFFFFFFF, 1'b0);
        push_raw(32'h7E7E0001, 1'b1);
        settle();

        // Goal of zero discards everything, a small goal cuts the stream.
        set_reg(REG_DEDUP_ENABLE, 32'd0);
        set_reg(REG_LEAD_SKIP, 32'd0);
        set_reg(REG_WORD_GOAL, 32'd0);
        push_raw(32'hCAFEF00D, 1'b0);
        push_raw(32'h0BADBEEF, 1'b1);
        settle();
        set_reg(REG_WORD_GOAL, 32'd2);
        push_raw(32'h01020304, 1'b0);
        push_raw(32'h05060708, 1'b0);
        push_raw(32'h090A0B0C, 1'b1);
        settle();

        // Dedup switched off with a word held: held word comes out first.
        set_reg(REG_WORD_GOAL, 32'hFFFFFF);
        set_reg(REG_DEDUP_ENABLE, 32'd1);
        push_raw(32'h55AA00FF, 1'b0);
        settle();
        set_reg(REG_DEDUP_ENABLE, 32'd0);
        push_raw(32'h0F0F0F0F, 1'b1);
        settle();

        // Skip count changed in the middle of a capture, up to its maximum.
        set_reg(REG_LEAD_SKIP, 32'd3);
        push_raw(32'h00000011, 1'b0);
        push_raw(32'h00000022, 1'b0);
        settle();
        set_reg(REG_LEAD_SKIP, 32'd1);
        push_raw(32'h00000033, 1'b0);
        settle();
        set_reg(REG_LEAD_SKIP, 32'hFFFFF);
        push_raw(32'h00000044, 1'b1);
        settle();

        // Random phases, each with some register settings drawn anew.
        sent = 0;
        w    = '0;
        while (sent < RANDOM_BEATS) begin
            if ($urandom_range(99) < 70) set_reg(REG_DEDUP_ENABLE, $urandom_range(1));
            if ($urandom_range(99) < 80) begin
                r = $urandom_range(99);
                if (r < 50)      set_reg(REG_LEAD_SKIP, $urandom_range(6));
                else if (r < 85) set_reg(REG_LEAD_SKIP, $urandom_range(7, 40));
                else if (r < 97) set_reg(REG_LEAD_SKIP, $urandom_range(41, 200));
                else             set_reg(REG_LEAD_SKIP, 32'hFFFFF);
            end
            if ($urandom_range(99) < 70) set_reg(REG_DROP_ZEROS, $urandom_range(1));
            if ($urandom_range(99) < 70) begin
                r = $urandom_range(99);
                if (r < 5)       set_reg(REG_WORD_GOAL, 32'd0);
                else if (r < 25) set_reg(REG_WORD_GOAL, $urandom_range(1, 20));
                else if (r < 60) set_reg(REG_WORD_GOAL, 32'hFFFFFF);
                else             set_reg(REG_WORD_GOAL, $urandom_range(1000, 32'hFFFFFF));
            end
            if ($urandom_range(99) < 70) set_reg(REG_SWAP_BYTES, $urandom_range(1));
            if ($urandom_range(99) < 70) set_reg(REG_REVERSE_BITS, $urandom_range(1));
            if ($urandom_range(99) < 70) set_reg(REG_SERIAL_MSB, $urandom_range(1));
            steady = ($urandom_range(99) < 20);
            n = $urandom_range(60, 180);
            for (int k = 0; k < n; k++) begin
                w = draw_word(w);
                push_raw(w, $urandom_range(39) == 0);
            end
            sent += n;
            settle();
            steady = 1'b0;
        end

        if (err_count == 0) begin
            $display("PASS capture_word_postprocess_unit");
        end else begin
            $display("FAIL capture_word_postprocess_unit");
        end
        $finish;
    end

endmodule
